### src/positional_list_engine_top_macros.svh
// ----------------------------------------------------------------------------
// Positional list engine assertion macros
// Shared concurrent assertion forms, clocked on clk and reset by arst_n.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_ENGINE_TOP_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_TOP_MACROS_SVH

// Checked only while out of reset.
`define PLE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every edge, during reset as well.
`define PLE_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/ple_pkg.sv
// ----------------------------------------------------------------------------
// Positional list engine package
// Command and status codes, decoded operation struct and default sizes.
// ----------------------------------------------------------------------------
package ple_pkg;

	localparam int DefaultDepth = 16;

	localparam int CmdW    = 3;
	localparam int PosW    = 5;
	localparam int DataW   = 32;
	localparam int StatusW = 2;
	localparam int CountW  = 5;

	typedef enum logic [CmdW-1:0] {
		CMD_ADD_FRONT   = 3'd0,
		CMD_ADD_REAR    = 3'd1,
		CMD_REM_FRONT   = 3'd2,
		CMD_REM_REAR    = 3'd3,
		CMD_INSERT_AT   = 3'd4,
		CMD_DELETE_AT   = 3'd5
	} cmd_t;

	typedef enum logic [StatusW-1:0] {
		ST_OK        = 2'd0,
		ST_UNDERFLOW = 2'd1,
		ST_RANGE     = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	// Decoded operation handed from the command decoder to the cell row.
	typedef struct packed {
		logic    ins;
		logic    del;
		status_t status;
	} op_t;

endpackage

### src/positional_list_engine_top.sv
// ----------------------------------------------------------------------------
// Positional list engine
// Ordered list of up to DEPTH words held in a row of shifting cells.
// ----------------------------------------------------------------------------
//  Channel | Handshake            | Payload
//  --------+----------------------+-----------------------------------------
//  in      | in_valid / in_ready  | command, position, value
//  out     | out_valid / out_ready| removed_value, status, entry_count
//
//  The decoder and the cell row act on each accepted word in the cycle
//  of acceptance, and the result is registered. A new word may be
//  accepted every cycle while the result register is empty or being
//  emptied; only a stalled output holds in_ready low.
//  Reset clears the count and the output valid flag; cell contents are left
//  undefined, as only cells below the count are ever read.
// ----------------------------------------------------------------------------
`include "positional_list_engine_top_macros.svh"

module positional_list_engine_top #(
	parameter int DEPTH = ple_pkg::DefaultDepth
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [ple_pkg::CmdW-1:0]        command,
	input  logic [ple_pkg::PosW-1:0]        position,
	input  logic signed [ple_pkg::DataW-1:0] value,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic signed [ple_pkg::DataW-1:0] removed_value,
	output logic [ple_pkg::StatusW-1:0]     status,
	output logic [ple_pkg::CountW-1:0]      entry_count
);
	import ple_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = $clog2(DEPTH);

	logic [CW-1:0]    count_q;
	logic             out_valid_q;
	logic [DataW-1:0] removed_value_q;
	status_t          status_q;
	logic [CountW-1:0] entry_count_q;

	logic             accept;
	op_t              op;
	logic [IW-1:0]    idx;
	logic [CW-1:0]    count_next;
	logic [DataW-1:0] removed_word;

	logic [DataW-1:0] cell_data [DEPTH];
	logic [DataW-1:0] cell_tap  [DEPTH];

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	// Command decode against the count held before this word.
	ple_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.command (command),
		.position(position),
		.count   (count_q),
		.op      (op),
		.idx     (idx)
	);

	// The row of cells: cell 0 is the front. On insert the cells behind the
	// index take their front neighbour's word; on removal the cells from the
	// index rearward take their rear neighbour's word.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DataW-1:0] prev_w;
		logic [DataW-1:0] next_w;

		if (i == 0) begin : g_front
			assign prev_w = value;
		end else begin : g_mid_prev
			assign prev_w = cell_data[i-1];
		end

		if (i == DEPTH - 1) begin : g_rear
			assign next_w = '0;
		end else begin : g_mid_next
			assign next_w = cell_data[i+1];
		end

		ple_cell #(
			.DEPTH     (DEPTH),
			.CELL_INDEX(i)
		) u_cell (
			.clk      (clk),
			.shift    (accept),
			.ins      (op.ins),
			.del      (op.del),
			.idx      (idx),
			.value    (value),
			.prev_data(prev_w),
			.next_data(next_w),
			.data     (cell_data[i]),
			.tap      (cell_tap[i])
		);
	end

	// At most one cell drives a non-zero tap, so an OR gathers the word
	// being taken out.
	always_comb begin
		removed_word = '0;
		for (int k = 0; k < DEPTH; k++) begin
			removed_word = removed_word | cell_tap[k];
		end
	end

	always_comb begin
		count_next = count_q;
		if (op.ins) count_next = count_q + CW'(1);
		else if (op.del) count_next = count_q - CW'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_next;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload: the entry count carries only its low bits.
	always_ff @(posedge clk) begin
		if (accept) begin
			removed_value_q <= op.del ? removed_word : '0;
			status_q        <= op.status;
			entry_count_q   <= CountW'(count_next);
		end
	end

	assign out_valid     = out_valid_q;
	assign removed_value = removed_value_q;
	assign status        = status_q;
	assign entry_count   = entry_count_q;

	`PLE_ASSERT(a_count_bound, (count_q <= CW'(DEPTH)), "count exceeds depth")
	`PLE_ASSERT(a_count_hold, (!accept |=> $stable(count_q)), "count moved without a word")
	`PLE_ASSERT(a_del_dec, (accept && op.del |=> count_q == $past(count_q) - CW'(1)), "removal did not lower count")
	`PLE_ASSERT(a_err_noop, (op.status != ST_OK |-> !op.ins && !op.del), "failed command changes list")
	`PLE_ASSERT_ALWAYS(a_rst_idle, (!arst_n |-> !out_valid), "result valid in reset")

endmodule

### src/ple_ctrl.sv
// ----------------------------------------------------------------------------
// Positional list engine command decoder
// Checks a command against the count and picks the cell index it acts on.
// ----------------------------------------------------------------------------
module ple_ctrl #(
	parameter int DEPTH = ple_pkg::DefaultDepth
) (
	input  logic [ple_pkg::CmdW-1:0]      command,
	input  logic [ple_pkg::PosW-1:0]      position,
	input  logic [$clog2(DEPTH+1)-1:0]    count,
	output ple_pkg::op_t                  op,
	output logic [$clog2(DEPTH)-1:0]      idx
);
	import ple_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = $clog2(DEPTH);
	localparam int PW = ((CW > PosW) ? CW : PosW) + 1;

	logic [PW-1:0] pos_w;
	logic [PW-1:0] cnt_w;
	logic [PW-1:0] idx_w;
	logic          full;
	logic          empty;

	assign pos_w = PW'(position);
	assign cnt_w = PW'(count);
	assign full  = (cnt_w >= PW'(DEPTH));
	assign empty = (count == '0);

	always_comb begin
		op     = '{ins: 1'b0, del: 1'b0, status: ST_OK};
		idx_w  = '0;
		unique case (cmd_t'(command))
			CMD_ADD_FRONT: begin
				if (full) op.status = ST_FULL;
				else op.ins = 1'b1;
			end
			CMD_ADD_REAR: begin
				idx_w = cnt_w;
				if (full) op.status = ST_FULL;
				else op.ins = 1'b1;
			end
			CMD_REM_FRONT: begin
				if (empty) op.status = ST_UNDERFLOW;
				else op.del = 1'b1;
			end
			CMD_REM_REAR: begin
				idx_w = cnt_w - PW'(1);
				if (empty) op.status = ST_UNDERFLOW;
				else op.del = 1'b1;
			end
			CMD_INSERT_AT: begin
				idx_w = pos_w - PW'(1);
				if (pos_w == '0 || pos_w > cnt_w + PW'(1)) op.status = ST_RANGE;
				else if (full) op.status = ST_FULL;
				else op.ins = 1'b1;
			end
			CMD_DELETE_AT: begin
				idx_w = pos_w - PW'(1);
				if (pos_w == '0 || pos_w > cnt_w) op.status = ST_RANGE;
				else op.del = 1'b1;
			end
			default: begin
				op.status = ST_OK;
			end
		endcase
	end

	// Only meaningful when ins or del is set, and then it lies below DEPTH.
	assign idx = idx_w[IW-1:0];

endmodule

### src/ple_cell.sv
// ----------------------------------------------------------------------------
// Positional list engine cell
// One list slot: holds, loads the new word, or takes a neighbour's word.
// ----------------------------------------------------------------------------
module ple_cell #(
	parameter int DEPTH      = ple_pkg::DefaultDepth,
	parameter int CELL_INDEX = 0
) (
	input  logic                          clk,
	input  logic                          shift,
	input  logic                          ins,
	input  logic                          del,
	input  logic [$clog2(DEPTH)-1:0]      idx,
	input  logic [ple_pkg::DataW-1:0]     value,
	input  logic [ple_pkg::DataW-1:0]     prev_data,
	input  logic [ple_pkg::DataW-1:0]     next_data,
	output logic [ple_pkg::DataW-1:0]     data,
	output logic [ple_pkg::DataW-1:0]     tap
);
	import ple_pkg::*;

	localparam int IW = $clog2(DEPTH);
	localparam logic [IW-1:0] MyIdx = IW'(CELL_INDEX);

	logic [DataW-1:0] data_q;
	logic             hit;
	logic             behind;

	assign hit    = (idx == MyIdx);
	assign behind = (MyIdx > idx);

	always_ff @(posedge clk) begin
		if (shift) begin
			if (ins && hit) data_q <= value;
			else if (ins && behind) data_q <= prev_data;
			else if (del && (hit || behind)) data_q <= next_data;
		end
	end

	assign data = data_q;
	// Masked copy so the row can be OR-combined for the removed word.
	assign tap  = hit ? data_q : '0;

endmodule

### sim/positional_list_engine_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Positional list engine testbench
// Drives command words through the input channel under changing idle and
// stall patterns, predicts every result from a shadow copy of the list and
// checks each returned word against the oldest outstanding prediction.
// ----------------------------------------------------------------------------

module positional_list_engine_top_tb;

	import ple_pkg::*;

	localparam int DEPTH           = DefaultDepth;
	localparam int CLK_HALF        = 10;
	localparam int ITEMS_PER_PHASE = 175;
	localparam int HOLD_CYCLES     = 400;
	localparam int SETTLE_CYCLES   = 8;
	localparam int CYCLE_LIMIT     = 200000;

	// The two command codes that the engine leaves unused.
	localparam logic [CmdW-1:0] CMD_SPARE_A = 3'd6;
	localparam logic [CmdW-1:0] CMD_SPARE_B = 3'd7;

	typedef struct {
		logic [CmdW-1:0]         command;
		logic [PosW-1:0]         position;
		logic signed [DataW-1:0] value;
	} list_word_t;

	typedef struct {
		logic signed [DataW-1:0] removed;
		status_t                 status;
		logic [CountW-1:0]       count;
	} list_result_t;

	logic                    clk        = 1'b0;
	logic                    arst_n     = 1'b1;
	logic                    in_valid   = 1'b0;
	logic                    in_ready;
	logic [CmdW-1:0]         command    = '0;
	logic [PosW-1:0]         position   = '0;
	logic signed [DataW-1:0] value      = '0;
	logic                    out_valid;
	logic                    out_ready  = 1'b0;
	logic signed [DataW-1:0] removed_value;
	logic [StatusW-1:0]      status;
	logic [CountW-1:0]       entry_count;

	// Words waiting to be offered, and results owed by the engine, oldest first.
	list_word_t   cmd_backlog[$];
	list_result_t owed_results[$];

	// Shadow of the list as the engine should hold it.
	logic signed [DataW-1:0] shadow_cells [DEPTH];
	int                      shadow_count = 0;

	// Set at each rising edge when the input word was taken at that edge.
	bit in_taken = 1'b0;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_requests  = 0;
	int hold_served    = 0;
	int hold_left      = 0;
	int mismatches     = 0;
	int cycle_count    = 0;

	positional_list_engine_top #(
		.DEPTH(DEPTH)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.command      (command),
		.position     (position),
		.value        (value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.removed_value(removed_value),
		.status       (status),
		.entry_count  (entry_count)
	);

	always #CLK_HALF clk = ~clk;

	// Applies one command word to the shadow list and returns the result that
	// the engine must give for it. Every command yields exactly one result.
	function automatic list_result_t predict_list_op(list_word_t w);
		list_result_t r;
		bit           grow;
		bit           shrink;
		int           at;
		r.removed = '0;
		r.status  = ST_OK;
		grow      = 1'b0;
		shrink    = 1'b0;
		at        = 0;
		case (w.command)
			CMD_ADD_FRONT, CMD_ADD_REAR: begin
				at   = (w.command == CMD_ADD_FRONT) ? 0 : shadow_count;
				grow = 1'b1;
			end
			CMD_REM_FRONT, CMD_REM_REAR: begin
				if (shadow_count == 0) begin
					r.status = ST_UNDERFLOW;
				end else begin
					at     = (w.command == CMD_REM_FRONT) ? 0 : shadow_count - 1;
					shrink = 1'b1;
				end
			end
			CMD_INSERT_AT: begin
				// An insert may go one place past the rear, giving an add at the rear.
				if (int'(w.position) < 1 || int'(w.position) > shadow_count + 1) begin
					r.status = ST_RANGE;
				end else begin
					at   = int'(w.position) - 1;
					grow = 1'b1;
				end
			end
			CMD_DELETE_AT: begin
				if (int'(w.position) < 1 || int'(w.position) > shadow_count) begin
					r.status = ST_RANGE;
				end else begin
					at     = int'(w.position) - 1;
					shrink = 1'b1;
				end
			end
			default: begin
				// The spare codes leave the list alone and report success.
			end
		endcase
		// Fullness is only looked at once the position has been found valid.
		if (grow && shadow_count >= DEPTH) begin
			r.status = ST_FULL;
			grow     = 1'b0;
		end
		if (grow) begin
			for (int k = shadow_count; k > at; k--)
				shadow_cells[k] = shadow_cells[k - 1];
			shadow_cells[at] = w.value;
			shadow_count++;
		end
		if (shrink) begin
			r.removed = shadow_cells[at];
			for (int k = at; k + 1 < shadow_count; k++)
				shadow_cells[k] = shadow_cells[k + 1];
			shadow_count--;
		end
		r.count = CountW'(shadow_count);
		return r;
	endfunction

	task automatic queue_word(logic [CmdW-1:0] c, logic [PosW-1:0] p,
			logic signed [DataW-1:0] v);
		list_word_t w;
		w.command  = c;
		w.position = p;
		w.value    = v;
		cmd_backlog.push_back(w);
	endtask

	function automatic logic signed [DataW-1:0] pick_value();
		case ($urandom_range(9))
			0:       return 32'sh8000_0000;
			1:       return 32'sh7FFF_FFFF;
			2:       return '0;
			3:       return '1;
			default: return $urandom;
		endcase
	endfunction

	// Queues n random words that do something, plus the odd spare code on top.
	// The words come in runs that lean towards growing or towards shrinking the
	// list, so that it is driven both full and empty again and again.
	task automatic queue_random_words(int n);
		int  made;
		int  lean;
		int  roll;
		logic [CmdW-1:0] c;
		logic [PosW-1:0] p;
		made = 0;
		while (made < n) begin
			case ((made / 24) % 4)
				0:       lean = 80;
				1:       lean = 55;
				2:       lean = 20;
				default: lean = 45;
			endcase
			roll = $urandom_range(99);
			if ($urandom_range(99) < 3) begin
				c = $urandom_range(1) ? CMD_SPARE_A : CMD_SPARE_B;
			end else if (roll < lean) begin
				case ($urandom_range(2))
					0:       c = CMD_ADD_FRONT;
					1:       c = CMD_ADD_REAR;
					default: c = CMD_INSERT_AT;
				endcase
				made++;
			end else begin
				case ($urandom_range(2))
					0:       c = CMD_REM_FRONT;
					1:       c = CMD_REM_REAR;
					default: c = CMD_DELETE_AT;
				endcase
				made++;
			end
			// Mostly positions near the list's size, now and then any 5-bit value.
			p = ($urandom_range(99) < 80) ? PosW'($urandom_range(17)) : PosW'($urandom_range(31));
			queue_word(c, p, pick_value());
		end
	endtask

	// Offers the words of one phase and returns once the last has been taken.
	task automatic run_phase(int send_pct, int recv_pct);
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
		queue_random_words(ITEMS_PER_PHASE);
		while (cmd_backlog.size() != 0 || in_valid)
			@(posedge clk);
	endtask

	// Sender. A new word is put up at the falling edge only once the previous
	// one has been taken; while waiting, valid and payload stay as they are.
	always @(negedge clk) begin
		list_word_t w;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_taken) begin
			if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				w = cmd_backlog.pop_front();
				in_valid <= 1'b1;
				command  <= w.command;
				position <= w.position;
				value    <= w.value;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver. A requested hold-off keeps ready low until hold_left runs
	// out, so that the result register fills and the engine stops taking
	// words; otherwise ready follows the stall rate of the current phase.
	always @(negedge clk) begin
		if (hold_served != hold_requests) begin
			hold_left   = HOLD_CYCLES;
			hold_served = hold_requests;
		end
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Monitor. The result side is looked at first: a result handed over at
	// this edge was registered earlier and so belongs to an older word than
	// any taken at the same edge.
	always @(posedge clk) begin
		list_result_t want;
		list_word_t   got_word;
		if (!arst_n) begin
			in_taken = 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (owed_results.size() == 0) begin
					$display("%0t: result with none owed: removed %0d status %0d count %0d",
						$time, removed_value, status, entry_count);
					mismatches++;
				end else begin
					want = owed_results.pop_front();
					if (removed_value !== want.removed || status !== want.status ||
							entry_count !== want.count) begin
						$display("%0t: mismatch: expected removed %0d status %0d count %0d, %s",
							$time, want.removed, want.status, want.count, "got");
						$display("%0t:           actual   removed %0d status %0d count %0d",
							$time, removed_value, status, entry_count);
						mismatches++;
					end
				end
			end
			in_taken = in_valid && in_ready;
			if (in_taken) begin
				got_word.command  = command;
				got_word.position = position;
				got_word.value    = value;
				owed_results.push_back(predict_list_op(got_word));
			end
		end
	end

	// Watchdog on the length of the run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: run stopped at the cycle limit", $time);
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		// Reset is pulled low just after time zero, so that the engine sees a
		// real falling edge on it.
		#1;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed words: underflow and range errors on the empty list, the
		// extreme values, both spare codes, a fill up to the full mark, adds
		// and inserts against a full list, and deletes at the rear, in the middle and at 0.
		queue_word(CMD_REM_FRONT, 5'd0, '0);
		queue_word(CMD_REM_REAR, 5'd0, '0);
		queue_word(CMD_DELETE_AT, 5'd1, '0);
		queue_word(CMD_INSERT_AT, 5'd0, 32'sh1234_5678);
		queue_word(CMD_INSERT_AT, 5'd1, 32'sh8000_0000);
		queue_word(CMD_ADD_FRONT, 5'd0, 32'sh7FFF_FFFF);
		queue_word(CMD_ADD_REAR, 5'd0, '1);
		queue_word(CMD_SPARE_A, 5'd0, '0);
		queue_word(CMD_SPARE_B, 5'd31, '1);
		for (int k = 0; k < DEPTH - 3; k++)
			queue_word((k % 3 == 0) ? CMD_INSERT_AT : ((k % 2) ? CMD_ADD_FRONT : CMD_ADD_REAR),
				PosW'((k + 3) / 2 + 1), (k == 0) ? '0 : $urandom);
		queue_word(CMD_ADD_REAR, 5'd0, 32'sh0BAD_F00D);
		queue_word(CMD_INSERT_AT, 5'd17, 32'sh0BAD_F00D);
		queue_word(CMD_INSERT_AT, 5'd18, 32'sh0BAD_F00D);
		queue_word(CMD_DELETE_AT, 5'd16, '0);
		queue_word(CMD_DELETE_AT, 5'd0, '0);
		queue_word(CMD_DELETE_AT, 5'd8, '0);
		while (cmd_backlog.size() != 0 || in_valid)
			@(posedge clk);

		// Phase without idling, opened by a long hold-off on the result side
		// while the sender keeps offering words.
		hold_requests++;
		run_phase(0, 0);
		run_phase(66, 0);
		run_phase(0, 66);
		run_phase(21, 21);

		while (owed_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
